FILE: rtl/sequence_replay_window_tracker_core_assert.svh
// Assertion helpers shared by the tracker RTL.
`ifndef SEQUENCE_REPLAY_WINDOW_TRACKER_CORE_ASSERT_SVH
`define SEQUENCE_REPLAY_WINDOW_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srwt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srwt check failed");

`endif

FILE: rtl/srwt_pkg.sv
`timescale 1ns / 1ps

package srwt_pkg;

  localparam int SEQ_W = 32;
  localparam int CNT_W = 32;

  typedef enum logic [1:0] {
    VERDICT_NEW       = 2'd0,
    VERDICT_REORDERED = 2'd1,
    VERDICT_DUPLICATE = 2'd2
  } verdict_t;

  // Classification of one packet, handed from the window logic to the counters
  typedef struct packed {
    logic first;    // first packet after reset
    logic fwd;      // ahead of the highest number
    logic reorder;  // late but inside the window, bit was clear
    logic dup;      // duplicate or too old
  } cls_t;

endpackage

FILE: rtl/srwt_if.sv
`timescale 1ns / 1ps

// Sequence number channel
interface srwt_seq_if
  import srwt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_number;

  modport source (output valid, output seq_number, input ready);
  modport sink   (input valid, input seq_number, output ready);
endinterface

// Result channel
interface srwt_res_if
  import srwt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       verdict;
  logic [SEQ_W-1:0] highest_seq;
  logic [CNT_W-1:0] received_count;
  logic [CNT_W-1:0] lost_count;
  logic [CNT_W-1:0] duplicate_count;
  logic [CNT_W-1:0] reordered_count;

  modport source (output valid, output verdict, output highest_seq, output received_count,
                  output lost_count, output duplicate_count, output reordered_count,
                  input ready);
  modport sink   (input valid, input verdict, input highest_seq, input received_count,
                  input lost_count, input duplicate_count, input reordered_count,
                  output ready);
endinterface

FILE: rtl/srwt_window.sv
`timescale 1ns / 1ps

// Classifies one sequence number against the top number and the window,
// and works out the next window.
module srwt_window
  import srwt_pkg::*;
#(
  parameter int WINDOW_SIZE = 32
) (
  input  logic                   seen,
  input  logic [SEQ_W-1:0]       top_seq,
  input  logic [WINDOW_SIZE-1:0] win,
  input  logic [SEQ_W-1:0]       seq,
  output cls_t                   cls,
  output verdict_t               verdict,
  output logic [SEQ_W-1:0]       gap,
  output logic [WINDOW_SIZE-1:0] win_nxt
);

  localparam int               IDX_W   = $clog2(WINDOW_SIZE);
  localparam logic [SEQ_W-1:0] WIN_LEN = SEQ_W'(WINDOW_SIZE);

  logic [SEQ_W-1:0] diff;
  logic [SEQ_W-1:0] back;
  logic [IDX_W-1:0] back_idx;
  logic             in_win;
  logic             bit_set;
  logic             fwd_hit;

  // Forward and backward distance, modulo 2^32
  assign diff     = seq - top_seq;
  assign back     = top_seq - seq;
  assign back_idx = back[IDX_W-1:0];
  assign in_win   = (back < WIN_LEN);
  assign bit_set  = in_win && win[back_idx];
  // ahead by 1 .. 2^31-1; exactly half the space counts as behind
  assign fwd_hit  = (diff != '0) && !diff[SEQ_W-1];
  assign gap      = diff;

  always_comb begin
    cls     = '0;
    verdict = VERDICT_NEW;
    win_nxt = win;
    if (!seen) begin
      cls.first = 1'b1;
      win_nxt   = WINDOW_SIZE'(1);
    end else if (fwd_hit) begin
      cls.fwd = 1'b1;
      if (diff >= WIN_LEN) begin
        win_nxt = WINDOW_SIZE'(1);
      end else begin
        win_nxt = (win << diff[IDX_W-1:0]) | WINDOW_SIZE'(1);
      end
    end else if (in_win && !bit_set) begin
      cls.reorder = 1'b1;
      verdict     = VERDICT_REORDERED;
      win_nxt     = win | (WINDOW_SIZE'(1) << back_idx);
    end else begin
      cls.dup = 1'b1;
      verdict = VERDICT_DUPLICATE;
    end
  end

endmodule

FILE: rtl/srwt_stats.sv
`timescale 1ns / 1ps

// Wrapping packet counters
module srwt_stats
  import srwt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  cls_t             cls,
  input  logic [SEQ_W-1:0] gap,
  output logic [CNT_W-1:0] received,
  output logic [CNT_W-1:0] lost,
  output logic [CNT_W-1:0] duplicate,
  output logic [CNT_W-1:0] reordered
);

  logic [CNT_W-1:0] rcv_r, rcv_nxt;
  logic [CNT_W-1:0] lost_r, lost_nxt;
  logic [CNT_W-1:0] dup_r, dup_nxt;
  logic [CNT_W-1:0] reo_r, reo_nxt;

  // Next counter values for the packet being retired
  always_comb begin
    rcv_nxt  = rcv_r;
    lost_nxt = lost_r;
    dup_nxt  = dup_r;
    reo_nxt  = reo_r;
    if (cls.first) begin
      rcv_nxt = CNT_W'(1);
    end
    if (cls.fwd) begin
      rcv_nxt  = rcv_r + CNT_W'(1);
      // gap minus one packets went missing (zero for the next in order)
      lost_nxt = lost_r + CNT_W'(gap) - CNT_W'(1);
    end
    if (cls.reorder) begin
      rcv_nxt = rcv_r + CNT_W'(1);
      reo_nxt = reo_r + CNT_W'(1);
    end
    if (cls.dup) begin
      dup_nxt = dup_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r  <= '0;
      lost_r <= '0;
      dup_r  <= '0;
      reo_r  <= '0;
    end else if (en) begin
      rcv_r  <= rcv_nxt;
      lost_r <= lost_nxt;
      dup_r  <= dup_nxt;
      reo_r  <= reo_nxt;
    end
  end

  assign received  = rcv_r;
  assign lost      = lost_r;
  assign duplicate = dup_r;
  assign reordered = reo_r;

endmodule

FILE: rtl/sequence_replay_window_tracker_core.sv
`timescale 1ns / 1ps
// Result path: an input transfer is captured in the input register, then its result in
// the state/result register.
// Throughput: one sequence number per cycle while the result side is not stalled; the
// window update and counter adds are combinational between the input and state registers.
// Reset (synchronous, rst_n low): clears all tracker state and counters, empties both
// stages. No clearing pass; input is accepted straight after reset.
`include "sequence_replay_window_tracker_core_assert.svh"

module sequence_replay_window_tracker_core
  import srwt_pkg::*;
#(
  parameter int WINDOW_SIZE = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  srwt_seq_if.sink     in_chan,
  srwt_res_if.source   out_chan
);

  logic                   in_valid_r;
  logic [SEQ_W-1:0]       in_seq_r;
  logic                   out_valid_r;
  verdict_t               verdict_r;
  logic                   seen_r;
  logic [SEQ_W-1:0]       top_r;
  logic [WINDOW_SIZE-1:0] win_r;

  logic                   adv;
  logic                   proc;
  logic                   in_ready;
  cls_t                   cls;
  verdict_t               verdict;
  logic [SEQ_W-1:0]       gap;
  logic [WINDOW_SIZE-1:0] win_nxt;

  // Handshake: the result stage frees up when empty or when its transfer completes
  assign adv           = !out_valid_r || out_chan.ready;
  assign proc          = in_valid_r && adv;
  assign in_ready      = !in_valid_r || adv;
  assign in_chan.ready = in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      in_seq_r <= in_chan.seq_number;
    end
  end

  // Window classification
  srwt_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .seen    (seen_r),
    .top_seq (top_r),
    .win     (win_r),
    .seq     (in_seq_r),
    .cls     (cls),
    .verdict (verdict),
    .gap     (gap),
    .win_nxt (win_nxt)
  );

  // Tracker state; also serves as the held result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      top_r  <= '0;
      win_r  <= '0;
    end else if (proc) begin
      seen_r <= 1'b1;
      win_r  <= win_nxt;
      if (cls.first || cls.fwd) begin
        top_r <= in_seq_r;
      end
    end
  end

  // Result valid and verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      verdict_r   <= VERDICT_NEW;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
      if (proc) begin
        verdict_r <= verdict;
      end
    end
  end

  // Counters
  srwt_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (proc),
    .cls       (cls),
    .gap       (gap),
    .received  (out_chan.received_count),
    .lost      (out_chan.lost_count),
    .duplicate (out_chan.duplicate_count),
    .reordered (out_chan.reordered_count)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.verdict     = verdict_r;
  assign out_chan.highest_seq = top_r;

  // Checks
  `SRWT_ASSERT_NEXT(a_proc_gives_result, clk, rst_n, proc, out_valid_r)
  `SRWT_ASSERT_IMPLY(a_newest_bit_set, clk, rst_n, seen_r, win_r[0])
  `SRWT_ASSERT_NEXT(a_first_packet, clk, rst_n, proc && !seen_r,
    seen_r && (out_chan.received_count == CNT_W'(1)))
  `SRWT_ASSERT_NEXT(a_dup_counts, clk, rst_n, proc && cls.dup,
    out_chan.duplicate_count == $past(out_chan.duplicate_count) + CNT_W'(1))
  `SRWT_ASSERT_IMPLY(a_free_when_empty, clk, rst_n, !out_valid_r, in_chan.ready)

endmodule

FILE: dv/sequence_replay_window_tracker_core_monitor.sv
`timescale 1ns / 1ps

// Watches both channels, tracks the replay window on its own and compares every result.
module sequence_replay_window_tracker_core_monitor
  import srwt_pkg::*;
#(
  parameter int WINDOW_SIZE = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  srwt_seq_if    seq_mon,
  srwt_res_if    res_mon,
  output int     fail_count,
  output int     pending
);

  typedef struct {
    verdict_t         verdict;
    logic [SEQ_W-1:0] highest_seq;
    logic [CNT_W-1:0] received_count;
    logic [CNT_W-1:0] lost_count;
    logic [CNT_W-1:0] duplicate_count;
    logic [CNT_W-1:0] reordered_count;
  } window_report_t;

  // Tracker state as the block should hold it
  logic                   seen_any;
  logic [SEQ_W-1:0]       top_seq;
  logic [WINDOW_SIZE-1:0] window_bits;
  logic [CNT_W-1:0]       received_total;
  logic [CNT_W-1:0]       lost_total;
  logic [CNT_W-1:0]       duplicate_total;
  logic [CNT_W-1:0]       reordered_total;

  window_report_t expected_reports[$];
  int             mismatch_total = 0;

  // Classify one sequence number and advance the window and counters
  task automatic track_packet(input logic [SEQ_W-1:0] seq, output window_report_t rep);
    logic [SEQ_W-1:0] ahead;
    logic [SEQ_W-1:0] behind;
    rep.verdict = VERDICT_NEW;
    if (!seen_any) begin
      seen_any       = 1'b1;
      top_seq        = seq;
      window_bits    = 1;
      received_total = 1;
    end else begin
      ahead  = seq - top_seq;
      behind = top_seq - seq;
      // ahead by 1 .. 2^31-1: slide the window forward
      if (ahead != 0 && !ahead[SEQ_W-1]) begin
        if (ahead >= WINDOW_SIZE) window_bits = 1;
        else window_bits = (window_bits << ahead) | 1;
        if (ahead > 1) lost_total = lost_total + (ahead - 1);
        top_seq        = seq;
        received_total = received_total + 1;
      end else if (behind >= WINDOW_SIZE || window_bits[behind]) begin
        // too old, half the space away, or already seen (same as top included)
        duplicate_total = duplicate_total + 1;
        rep.verdict     = VERDICT_DUPLICATE;
      end else begin
        window_bits[behind] = 1'b1;
        reordered_total     = reordered_total + 1;
        received_total      = received_total + 1;
        rep.verdict         = VERDICT_REORDERED;
      end
    end
    rep.highest_seq     = top_seq;
    rep.received_count  = received_total;
    rep.lost_count      = lost_total;
    rep.duplicate_count = duplicate_total;
    rep.reordered_count = reordered_total;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    window_report_t predicted;
    window_report_t due;
    if (!rst_n) begin
      seen_any        = 1'b0;
      top_seq         = '0;
      window_bits     = '0;
      received_total  = '0;
      lost_total      = '0;
      duplicate_total = '0;
      reordered_total = '0;
      expected_reports.delete();
    end else begin
      if (seq_mon.valid && seq_mon.ready) begin
        track_packet(seq_mon.seq_number, predicted);
        expected_reports.push_back(predicted);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_total++;
          $display("%0t: result with nothing expected, got verdict %0d highest %0h",
                   $time, res_mon.verdict, res_mon.highest_seq);
        end else begin
          due = expected_reports.pop_front();
          check_field("verdict", due.verdict, res_mon.verdict);
          check_field("highest_seq", due.highest_seq, res_mon.highest_seq);
          check_field("received_count", due.received_count, res_mon.received_count);
          check_field("lost_count", due.lost_count, res_mon.lost_count);
          check_field("duplicate_count", due.duplicate_count, res_mon.duplicate_count);
          check_field("reordered_count", due.reordered_count, res_mon.reordered_count);
        end
      end
    end
    fail_count <= mismatch_total;
    pending    <= expected_reports.size();
  end

endmodule

FILE: dv/sequence_replay_window_tracker_core_test.sv
`timescale 1ns / 1ps

module sequence_replay_window_tracker_core_test
  import srwt_pkg::*;
();

  localparam int WINDOW       = 32;
  localparam int RANDOM_ITEMS = 430;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  // No-gap stretches on both sides
  logic steady = 1'b0;

  // Highest number as the stimulus sees it, to aim items around the window
  logic             shadow_seen = 1'b0;
  logic [SEQ_W-1:0] shadow_top  = '0;

  srwt_seq_if in_if ();
  srwt_res_if out_if ();

  sequence_replay_window_tracker_core #(
    .WINDOW_SIZE(WINDOW)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  sequence_replay_window_tracker_core_monitor #(
    .WINDOW_SIZE(WINDOW)
  ) u_monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .seq_mon   (in_if),
    .res_mon   (out_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99, 0);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Mostly near the top of the window, the rest anywhere
  function automatic logic [SEQ_W-1:0] pick_seq();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 40) return shadow_top + $urandom_range(4, 1);
    if (roll < 65) return shadow_top - $urandom_range(40, 0);
    if (roll < 75) return shadow_top + $urandom_range(40, 5);
    if (roll < 80) return shadow_top + $urandom_range(32'h7FFF_FFFF, 41);
    if (roll < 85) return shadow_top ^ 32'h8000_0000;
    if (roll < 90) return shadow_top - $urandom_range(32'h7FFF_FFFF, 41);
    return $urandom();
  endfunction

  // One transfer on the sequence channel, after a random gap
  task automatic offer_seq(input logic [SEQ_W-1:0] seq);
    int               gap;
    logic [SEQ_W-1:0] ahead;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.seq_number <= seq;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ahead = seq - shadow_top;
    if (!shadow_seen || (ahead != 0 && !ahead[SEQ_W-1])) shadow_top = seq;
    shadow_seen = 1'b1;
  endtask

  // Result side stalls
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  // Reset, directed items, random items, drain and verdict
  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.seq_number <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    offer_seq(32'hFFFF_FFF0);                // first packet starts the window
    offer_seq(shadow_top);                   // same as highest
    offer_seq(shadow_top + 1);
    offer_seq(shadow_top + 21);              // forward across the wrap
    offer_seq(shadow_top - 1);               // late, inside window
    offer_seq(shadow_top - 1);               // same late one again
    offer_seq(shadow_top - (WINDOW - 1));    // oldest slot of the window
    offer_seq(shadow_top - WINDOW);          // just out of the window
    offer_seq(shadow_top ^ 32'h8000_0000);   // half the number space away
    offer_seq(shadow_top + 32'h7FFF_FFFF);   // largest forward jump
    offer_seq(shadow_top + WINDOW);          // jump of exactly the window size
    offer_seq(shadow_top - (WINDOW - 1));
    offer_seq(shadow_top + (WINDOW - 1));
    offer_seq(shadow_top - 32'h7FFF_FFFF);   // far behind
    offer_seq(shadow_top + 32'h7FFF_FFFF);   // lost count wraps over these
    offer_seq(shadow_top + 32'h7FFF_FFFF);
    offer_seq(32'hFFFF_FFFF);
    offer_seq(32'h0000_0000);
    offer_seq(32'hAAAA_AAAA);
    offer_seq(32'h5555_5555);
    offer_seq(shadow_top + 2);
    offer_seq(shadow_top - 1);               // fills the gap just left

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = ((i / 60) % 4 == 2);
      offer_seq(pick_seq());
    end
    steady = 1'b0;
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
